/* rtl/stepper_trapezoid_ramp_assert.svh */
// Assertion macros shared by the stepper ramp RTL.
`ifndef STEPPER_TRAPEZOID_RAMP_ASSERT_SVH
`define STEPPER_TRAPEZOID_RAMP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define STPR_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define STPR_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STPR_ASSERT(name, clk, rst, prop, msg)
`define STPR_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

/* rtl/stpr_pkg.sv */
// Constants and types for the trapezoidal stepper ramp generator.
`timescale 1ns / 1ps
package stpr_pkg;

  localparam int RATE_W   = 16;
  localparam int POS_W    = 32;
  localparam int RELOAD_W = 20;
  localparam int DIV_W    = 20;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [RELOAD_W-1:0] TICKS_PER_SEC = 20'd1000000;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  typedef enum logic [1:0] {
    REG_MIN_RATE = 2'd0,
    REG_MAX_RATE = 2'd1,
    REG_RATE_INC = 2'd2,
    REG_AUTO_EN  = 2'd3
  } stpr_reg_t;

endpackage

/* rtl/stepper_trapezoid_ramp.sv */
// Trapezoidal step-rate profile generator with a shared serial divider.
//
//  channel | handshake             | word
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_ready   | cmd, move_target
//  out     | out_valid / out_ready | step_pulse .. position (one per input)
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// Tick that steps: bookkeeping, then the 1000000/rate division on the single
// restoring divider; a tick that stops or finds no move running skips it.
// Move: distance, padding, ramp division, plan, reload division; the ramp
// division is skipped when max_rate <= min_rate or rate_inc is 0. A move
// during a move does only the reload division. Reset is synchronous.
// The next word is taken while a result waits in the output register; the
// finished result holds back the sequencer only while that register is full.
`timescale 1ns / 1ps
`include "stepper_trapezoid_ramp_assert.svh"

module stepper_trapezoid_ramp
  import stpr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  logic [POS_W-1:0]    move_target,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                step_pulse,
  output logic                direction,
  output logic                drive_enable,
  output logic                busy_res,
  output logic                timer_run,
  output logic [RELOAD_W-1:0] reload_period,
  output logic [POS_W-1:0]    position,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [RATE_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_MOVE, S_PAD, S_RAMP_DIV, S_PLAN, S_TICK, S_RATE_DIV, S_FINISH
  } state_t;

  state_t state;

  logic [RATE_W-1:0] min_rate, max_rate, rate_inc;
  logic              auto_en;

  logic [POS_W-1:0]  item_target;
  logic [POS_W-1:0]  cur_position, steps_done, steps_total, accel_end, decel_start;
  logic [RATE_W-1:0] cur_rate, ramp_len;
  logic              moving, dir_flag, enable_flag, pulse;

  // shared divider
  logic [RATE_W-1:0]    div_rem, div_den;
  logic [DIV_W-1:0]     div_quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [RATE_W:0]      rem_shift;
  logic [RATE_W+1:0]    rem_diff;
  logic                 qbit;
  logic [RATE_W-1:0]    rem_new;
  logic [DIV_W-1:0]     quo_new;

  logic [RATE_W:0]   rate_sum;
  logic [RATE_W-1:0] rate_next;
  logic [POS_W-1:0]  half_steps;
  logic              fwd;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    rem_shift = {div_rem, div_quo[DIV_W-1]};
    rem_diff  = {1'b0, rem_shift} - {2'b00, div_den};
    qbit      = ~rem_diff[RATE_W+1];
    rem_new   = qbit ? rem_diff[RATE_W-1:0] : rem_shift[RATE_W-1:0];
    quo_new   = {div_quo[DIV_W-2:0], qbit};
  end

  always_comb begin
    rate_sum  = {1'b0, cur_rate} + {1'b0, rate_inc};
    rate_next = cur_rate;
    if (steps_done < accel_end) begin
      rate_next = rate_sum[RATE_W] ? {RATE_W{1'b1}} : rate_sum[RATE_W-1:0];
    end else if (steps_done >= decel_start) begin
      rate_next = (cur_rate > rate_inc) ? cur_rate - rate_inc : '0;
    end
  end

  assign half_steps = {1'b0, steps_total[POS_W-1:1]};
  assign fwd        = $signed(item_target) > $signed(cur_position);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      min_rate     <= 16'd100;
      max_rate     <= 16'd1000;
      rate_inc     <= 16'd10;
      auto_en      <= 1'b0;
      cur_position <= '0;
      steps_done   <= '0;
      steps_total  <= '0;
      accel_end    <= '0;
      decel_start  <= '0;
      cur_rate     <= '0;
      moving       <= 1'b0;
      dir_flag     <= 1'b1;
      enable_flag  <= 1'b0;
      div_cnt      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (stpr_reg_t'(cfg_index))
          REG_MIN_RATE: min_rate <= cfg_data;
          REG_MAX_RATE: max_rate <= cfg_data;
          REG_RATE_INC: rate_inc <= cfg_data;
          REG_AUTO_EN:  auto_en  <= cfg_data[0];
          default:      ;
        endcase
      end

      // a finishing item refills the register itself
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_target <= move_target;
            pulse       <= 1'b0;
            if (cmd == CMD_TICK) begin
              state <= S_TICK;
            end else if (moving) begin
              // move while moving: drop it, report reload of the running rate
              div_quo <= TICKS_PER_SEC;
              div_rem <= '0;
              div_den <= cur_rate;
              div_cnt <= DIV_CNT_W'(DIV_W);
              state   <= S_RATE_DIV;
            end else begin
              state <= S_MOVE;
            end
          end
        end

        S_MOVE: begin
          dir_flag    <= fwd;
          steps_total <= fwd ? item_target - cur_position : cur_position - item_target;
          state       <= S_PAD;
        end

        S_PAD: begin
          // pad odd counts to even, except the all-ones count
          if (steps_total[0] && !(&steps_total)) begin
            steps_total <= steps_total + POS_W'(1);
          end
          if (max_rate > min_rate && rate_inc != '0) begin
            div_quo <= {{(DIV_W-RATE_W){1'b0}}, max_rate - min_rate};
            div_rem <= '0;
            div_den <= rate_inc;
            div_cnt <= DIV_CNT_W'(DIV_W);
            state   <= S_RAMP_DIV;
          end else begin
            ramp_len <= '0;
            state    <= S_PLAN;
          end
        end

        S_RAMP_DIV: begin
          div_rem <= rem_new;
          div_quo <= quo_new;
          div_cnt <= div_cnt - DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(1)) begin
            ramp_len <= quo_new[RATE_W-1:0];
            state    <= S_PLAN;
          end
        end

        S_PLAN: begin
          if ({{(POS_W-RATE_W){1'b0}}, ramp_len} > half_steps) begin
            accel_end   <= half_steps;
            decel_start <= half_steps;
          end else begin
            accel_end   <= {{(POS_W-RATE_W){1'b0}}, ramp_len};
            decel_start <= steps_total - {{(POS_W-RATE_W){1'b0}}, ramp_len};
          end
          steps_done <= '0;
          cur_rate   <= min_rate;
          moving     <= 1'b1;
          if (auto_en) begin
            enable_flag <= 1'b1;
          end
          div_quo <= TICKS_PER_SEC;
          div_rem <= '0;
          div_den <= min_rate;
          div_cnt <= DIV_CNT_W'(DIV_W);
          state   <= S_RATE_DIV;
        end

        S_TICK: begin
          if (!moving || steps_done >= steps_total) begin
            if (auto_en) begin
              enable_flag <= 1'b0;
            end
            moving   <= 1'b0;
            cur_rate <= '0;
            state    <= S_FINISH;
          end else begin
            cur_rate     <= rate_next;
            steps_done   <= steps_done + POS_W'(1);
            cur_position <= dir_flag ? cur_position + POS_W'(1) : cur_position - POS_W'(1);
            pulse        <= 1'b1;
            div_quo      <= TICKS_PER_SEC;
            div_rem      <= '0;
            div_den      <= rate_next;
            div_cnt      <= DIV_CNT_W'(DIV_W);
            state        <= S_RATE_DIV;
          end
        end

        S_RATE_DIV: begin
          div_rem <= rem_new;
          div_quo <= quo_new;
          div_cnt <= div_cnt - DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(1)) begin
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            step_pulse   <= pulse;
            direction    <= dir_flag;
            drive_enable <= enable_flag;
            busy_res     <= moving;
            timer_run    <= moving;
            position     <= cur_position;
            if (!moving) begin
              reload_period <= '0;
            end else if (cur_rate == '0) begin
              reload_period <= TICKS_PER_SEC;
            end else begin
              reload_period <= div_quo;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `STPR_ASSERT(a_done_le_total, clk, rst, moving |-> (steps_done <= steps_total), "steps_done passed steps_total")
  `STPR_ASSERT(a_ramp_order, clk, rst, moving |-> (accel_end <= decel_start), "accel_end after decel_start")
  `STPR_ASSERT(a_div_idle, clk, rst, (state != S_RAMP_DIV && state != S_RATE_DIV) |-> (div_cnt == '0), "divider count live outside a division")
  `STPR_ASSERT(a_idle_reload, clk, rst, (out_valid && !busy_res) |-> (reload_period == '0), "reload nonzero while stopped")

endmodule
